### rtl/core/lps_pkg.sv
// Shared constants and command codes for the line pixel stepper.
package lps_pkg;

    localparam int LPS_COORD_BITS  = 12;
    localparam int LPS_COLOR_BITS  = 32;
    localparam int LPS_QUEUE_DEPTH = 2;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

endpackage

### rtl/core/lps_front.sv
// Front end: classifies a start request into major/minor axes, ordered endpoints and deltas.
module lps_front #(
    parameter int COORD_BITS = lps_pkg::LPS_COORD_BITS
) (
    input  logic [COORD_BITS-1:0]        i_start_x,
    input  logic [COORD_BITS-1:0]        i_start_y,
    input  logic [COORD_BITS-1:0]        i_end_x,
    input  logic [COORD_BITS-1:0]        i_end_y,
    output logic                         o_steep,
    output logic [COORD_BITS-1:0]        o_major_pos,
    output logic [COORD_BITS-1:0]        o_major_end,
    output logic [COORD_BITS-1:0]        o_minor_pos,
    output logic [COORD_BITS-1:0]        o_major_delta,
    output logic [COORD_BITS-1:0]        o_minor_delta,
    output logic                         o_minor_down,
    output logic signed [COORD_BITS+1:0] o_err_first
);

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] ma;
    logic [COORD_BITS-1:0] mb;
    logic [COORD_BITS-1:0] mi;
    logic [COORD_BITS-1:0] nb;
    logic                  swap_ends;
    logic [COORD_BITS-1:0] minor_far;

    assign dx = (i_start_x > i_end_x) ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
    assign dy = (i_start_y > i_end_y) ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
    assign o_steep = (dy > dx);

    assign ma = o_steep ? i_start_y : i_start_x;
    assign mi = o_steep ? i_start_x : i_start_y;
    assign mb = o_steep ? i_end_y   : i_end_x;
    assign nb = o_steep ? i_end_x   : i_end_y;

    // order endpoints so the major coordinate rises
    assign swap_ends   = (ma > mb);
    assign o_major_pos = swap_ends ? mb : ma;
    assign o_major_end = swap_ends ? ma : mb;
    assign o_minor_pos = swap_ends ? nb : mi;
    assign minor_far   = swap_ends ? mi : nb;

    assign o_major_delta = o_steep ? dy : dx;
    assign o_minor_delta = o_steep ? dx : dy;
    assign o_minor_down  = (o_minor_pos > minor_far);

    // error after the first pixel: half the major delta less the minor delta
    assign o_err_first = $signed({2'b00, (o_major_delta >> 1)})
                       - $signed({2'b00, o_minor_delta});

endmodule

### rtl/core/lps_queue.sv
// Short request queue between the front end and the stepping engine.
module lps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lps_pkg::LPS_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/core/lps_back.sv
// Stepping engine: holds the line state, emits one result per request into the output register.
module lps_back #(
    parameter int COORD_BITS = lps_pkg::LPS_COORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    output logic                                o_q_pop,
    input  logic                                i_q_command,
    input  logic                                i_q_steep,
    input  logic [COORD_BITS-1:0]               i_q_major_pos,
    input  logic [COORD_BITS-1:0]               i_q_major_end,
    input  logic [COORD_BITS-1:0]               i_q_minor_pos,
    input  logic [COORD_BITS-1:0]               i_q_major_delta,
    input  logic [COORD_BITS-1:0]               i_q_minor_delta,
    input  logic                                i_q_minor_down,
    input  logic signed [COORD_BITS+1:0]        i_q_err_first,
    input  logic [lps_pkg::LPS_COLOR_BITS-1:0]  i_q_color,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [COORD_BITS-1:0]               o_pixel_x,
    output logic [COORD_BITS-1:0]               o_pixel_y,
    output logic [lps_pkg::LPS_COLOR_BITS-1:0]  o_pixel_color,
    output logic                                o_pixel_valid,
    output logic                                o_last_pixel
);

    localparam int EW = COORD_BITS + 2;

    // line state
    logic [COORD_BITS-1:0]              r_major_pos, n_major_pos;
    logic [COORD_BITS-1:0]              r_major_end, n_major_end;
    logic [COORD_BITS-1:0]              r_minor_pos, n_minor_pos;
    logic signed [EW-1:0]               r_error,     n_error;
    logic [COORD_BITS-1:0]              r_major_delta, n_major_delta;
    logic [COORD_BITS-1:0]              r_minor_delta, n_minor_delta;
    logic                               r_minor_down, n_minor_down;
    logic                               r_steep,     n_steep;
    logic                               r_active,    n_active;
    logic [lps_pkg::LPS_COLOR_BITS-1:0] r_color,     n_color;

    // output register
    logic                               r_o_valid;
    logic [COORD_BITS-1:0]              r_px, n_px;
    logic [COORD_BITS-1:0]              r_py, n_py;
    logic [lps_pkg::LPS_COLOR_BITS-1:0] r_pc, n_pc;
    logic                               r_pv, n_pv;
    logic                               r_last, n_last;

    logic                               advance;
    logic                               is_start;
    logic                               emit;
    logic [COORD_BITS-1:0]              cur_major;
    logic [COORD_BITS-1:0]              cur_end;
    logic [COORD_BITS-1:0]              cur_minor;
    logic [COORD_BITS-1:0]              cur_major_delta;
    logic [COORD_BITS-1:0]              cur_minor_delta;
    logic                               cur_down;
    logic                               cur_steep;
    logic [lps_pkg::LPS_COLOR_BITS-1:0] cur_color;
    logic                               at_end;
    logic signed [EW-1:0]               err_sub;

    // advance when the output register is empty or being drained
    assign advance  = i_q_valid && (!r_o_valid || i_ready);
    assign o_q_pop  = advance;
    assign is_start = (i_q_command == lps_pkg::CMD_START);
    assign emit     = is_start || r_active;

    assign cur_major       = is_start ? i_q_major_pos   : r_major_pos;
    assign cur_end         = is_start ? i_q_major_end   : r_major_end;
    assign cur_minor       = is_start ? i_q_minor_pos   : r_minor_pos;
    assign cur_major_delta = is_start ? i_q_major_delta : r_major_delta;
    assign cur_minor_delta = is_start ? i_q_minor_delta : r_minor_delta;
    assign cur_down        = is_start ? i_q_minor_down  : r_minor_down;
    assign cur_steep       = is_start ? i_q_steep       : r_steep;
    assign cur_color       = is_start ? i_q_color       : r_color;
    assign at_end          = (cur_major == cur_end);

    assign err_sub = is_start ? i_q_err_first
                              : (r_error - $signed({2'b00, r_minor_delta}));

    always_comb begin
        n_major_pos   = r_major_pos;
        n_major_end   = r_major_end;
        n_minor_pos   = r_minor_pos;
        n_error       = r_error;
        n_major_delta = r_major_delta;
        n_minor_delta = r_minor_delta;
        n_minor_down  = r_minor_down;
        n_steep       = r_steep;
        n_active      = r_active;
        n_color       = r_color;
        n_px          = '0;
        n_py          = '0;
        n_pc          = '0;
        n_pv          = 1'b0;
        n_last        = 1'b0;
        if (emit) begin
            n_px   = cur_steep ? cur_minor : cur_major;
            n_py   = cur_steep ? cur_major : cur_minor;
            n_pc   = cur_color;
            n_pv   = 1'b1;
            n_last = at_end;

            n_major_end   = cur_end;
            n_major_delta = cur_major_delta;
            n_minor_delta = cur_minor_delta;
            n_minor_down  = cur_down;
            n_steep       = cur_steep;
            n_color       = cur_color;
            n_active      = !at_end;
            n_major_pos   = cur_major;
            n_minor_pos   = cur_minor;
            n_error       = err_sub;
            if (!at_end) begin
                n_major_pos = cur_major + 1'b1;
                // step the minor axis when the error goes negative
                if (err_sub < 0) begin
                    n_minor_pos = cur_down ? (cur_minor - 1'b1) : (cur_minor + 1'b1);
                    n_error     = err_sub + $signed({2'b00, cur_major_delta});
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_active  <= n_active;
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_major_pos   <= n_major_pos;
            r_major_end   <= n_major_end;
            r_minor_pos   <= n_minor_pos;
            r_error       <= n_error;
            r_major_delta <= n_major_delta;
            r_minor_delta <= n_minor_delta;
            r_minor_down  <= n_minor_down;
            r_steep       <= n_steep;
            r_color       <= n_color;
            r_px          <= n_px;
            r_py          <= n_py;
            r_pc          <= n_pc;
            r_pv          <= n_pv;
            r_last        <= n_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pc;
    assign o_pixel_valid = r_pv;
    assign o_last_pixel  = r_last;

endmodule

### rtl/core/line_pixel_stepper_unit.sv
// Top level of the Bresenham line pixel stepper: front end, request queue and stepping engine.
//
//  channel   direction  handshake           payload
//  request   in         i_valid / o_ready   i_command, i_start_x/y, i_end_x/y, i_line_color
//  pixel     out        o_valid / i_ready   o_pixel_x/y, o_pixel_color, o_pixel_valid,
//                                           o_last_pixel
//
// Sustained rate is one request per cycle while i_ready holds; every request yields exactly one pixel result.
// The two-entry queue captures a request at the accepting edge; the engine then loads the output
// register from the queue head once that register is empty or being drained.
// The engine's combinational add, compare and increment on the error term sets the rate.
// Reset (synchronous, active low) empties the queue, drops any line and clears o_valid.
// A stall on the pixel side fills the queue; o_ready falls once both entries are held.
module line_pixel_stepper_unit #(
    parameter int COORD_BITS = lps_pkg::LPS_COORD_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_command,
    input  logic [COORD_BITS-1:0]              i_start_x,
    input  logic [COORD_BITS-1:0]              i_start_y,
    input  logic [COORD_BITS-1:0]              i_end_x,
    input  logic [COORD_BITS-1:0]              i_end_y,
    input  logic [lps_pkg::LPS_COLOR_BITS-1:0] i_line_color,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [COORD_BITS-1:0]              o_pixel_x,
    output logic [COORD_BITS-1:0]              o_pixel_y,
    output logic [lps_pkg::LPS_COLOR_BITS-1:0] o_pixel_color,
    output logic                               o_pixel_valid,
    output logic                               o_last_pixel
);

    typedef struct packed {
        logic                               command;
        logic                               steep;
        logic [COORD_BITS-1:0]              major_pos;
        logic [COORD_BITS-1:0]              major_end;
        logic [COORD_BITS-1:0]              minor_pos;
        logic [COORD_BITS-1:0]              major_delta;
        logic [COORD_BITS-1:0]              minor_delta;
        logic                               minor_down;
        logic signed [COORD_BITS+1:0]       err_first;
        logic [lps_pkg::LPS_COLOR_BITS-1:0] color;
    } t_entry;

    t_entry push_entry;
    t_entry head_entry;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;

    lps_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .o_steep       (push_entry.steep),
        .o_major_pos   (push_entry.major_pos),
        .o_major_end   (push_entry.major_end),
        .o_minor_pos   (push_entry.minor_pos),
        .o_major_delta (push_entry.major_delta),
        .o_minor_delta (push_entry.minor_delta),
        .o_minor_down  (push_entry.minor_down),
        .o_err_first   (push_entry.err_first)
    );

    assign push_entry.command = i_command;
    assign push_entry.color   = i_line_color;
    assign o_ready            = !q_full;

    lps_queue #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (lps_pkg::LPS_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  (push_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (head_entry),
        .i_pop   (q_pop)
    );

    lps_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .o_q_pop         (q_pop),
        .i_q_command     (head_entry.command),
        .i_q_steep       (head_entry.steep),
        .i_q_major_pos   (head_entry.major_pos),
        .i_q_major_end   (head_entry.major_end),
        .i_q_minor_pos   (head_entry.minor_pos),
        .i_q_major_delta (head_entry.major_delta),
        .i_q_minor_delta (head_entry.minor_delta),
        .i_q_minor_down  (head_entry.minor_down),
        .i_q_err_first   (head_entry.err_first),
        .i_q_color       (head_entry.color),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_color   (o_pixel_color),
        .o_pixel_valid   (o_pixel_valid),
        .o_last_pixel    (o_last_pixel)
    );

endmodule

### rtl/core/lps_checker.sv
// Port-level checks for the line pixel stepper, bound to the top level.
module lps_port_checker #(
    parameter int COORD_BITS = lps_pkg::LPS_COORD_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_ready,
    input  logic                               o_valid,
    input  logic                               i_ready,
    input  logic [COORD_BITS-1:0]              o_pixel_x,
    input  logic [COORD_BITS-1:0]              o_pixel_y,
    input  logic [lps_pkg::LPS_COLOR_BITS-1:0] o_pixel_color,
    input  logic                               o_pixel_valid,
    input  logic                               o_last_pixel
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_x) && $stable(o_pixel_y)
            && $stable(o_pixel_color) && $stable(o_pixel_valid) && $stable(o_last_pixel))
        else $error("pixel result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a step with no line gives an all-zero result
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pixel_valid |-> o_pixel_x == '0 && o_pixel_y == '0
            && o_pixel_color == '0 && !o_last_pixel)
        else $error("non-pixel result carries data");

    // with no result waiting the queue drains every cycle, so input stays open
    a_ready_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with no pending result");

endmodule

bind line_pixel_stepper_unit lps_port_checker #(.COORD_BITS(COORD_BITS)) u_lps_checker (.*);
